[sv/base58_decoder_assert.svh]
// ----------------------------------------------------------------------------
// Base58 decoder assertion macros
// Concurrent assertion shorthands for the decoder, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BASE58_DECODER_ASSERT_SVH
`define BASE58_DECODER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define B58_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define B58_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/b58_pkg.sv]
// ----------------------------------------------------------------------------
// Base58 decoder package
// Sizes, character constants, control-word encoding, the microprogram and
// the alphabet lookup shared by the decoder modules.
// ----------------------------------------------------------------------------
package b58_pkg;

	localparam int MAX_OUT     = 64;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int LEN_W       = 7;
	localparam int CARRY_W     = 6;
	localparam int PROD_W      = 14;
	localparam int RADIX       = 58;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [LEN_W-1:0]  len_t;

	localparam logic [LEN_W:0] MAX_TOTAL  = (LEN_W+1)'(MAX_OUT);
	localparam logic [7:0]     CHAR_ONE   = 8'h31;
	localparam logic [7:0]     HIGH_BIT   = 8'h80;
	localparam logic [7:0]     DIGIT_NONE = 8'hFF;

	typedef logic [3:0] op_t;
	localparam op_t OP_NONE  = 4'd0;
	localparam op_t OP_LOAD  = 4'd1;
	localparam op_t OP_CHAR  = 4'd2;
	localparam op_t OP_MUL   = 4'd3;
	localparam op_t OP_GROW  = 4'd4;
	localparam op_t OP_EMITZ = 4'd5;
	localparam op_t OP_BSET  = 4'd6;
	localparam op_t OP_EMITB = 4'd7;
	localparam op_t OP_CLEAR = 4'd8;
	localparam op_t OP_ERR   = 4'd9;

	typedef logic [1:0] wsel_t;
	localparam wsel_t W_NONE    = 2'd0;
	localparam wsel_t W_NOIN    = 2'd1;
	localparam wsel_t W_OUTBUSY = 2'd2;

	typedef logic [3:0] csel_t;
	localparam csel_t C_NEVER  = 4'd0;
	localparam csel_t C_ALWAYS = 4'd1;
	localparam csel_t C_NODIG  = 4'd2;
	localparam csel_t C_MORE   = 4'd3;
	localparam csel_t C_NOFIN  = 4'd4;
	localparam csel_t C_BAD    = 4'd5;
	localparam csel_t C_ZPZERO = 4'd6;
	localparam csel_t C_ZMORE  = 4'd7;
	localparam csel_t C_BMORE  = 4'd8;

	typedef logic [3:0] step_t;
	localparam step_t STEP_IDLE  = 4'd0;
	localparam step_t STEP_CHAR  = 4'd1;
	localparam step_t STEP_MUL   = 4'd2;
	localparam step_t STEP_GROW  = 4'd3;
	localparam step_t STEP_FIN   = 4'd4;
	localparam step_t STEP_BAD   = 4'd5;
	localparam step_t STEP_ZCHK  = 4'd6;
	localparam step_t STEP_EMITZ = 4'd7;
	localparam step_t STEP_BSET  = 4'd8;
	localparam step_t STEP_EMITB = 4'd9;
	localparam step_t STEP_CLEAR = 4'd10;
	localparam step_t STEP_ERR   = 4'd11;

	typedef struct packed {
		op_t   op;
		wsel_t wsel;
		csel_t csel;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic in_valid;
		logic out_busy;
		logic nodig;
		logic more;
		logic nofin;
		logic bad;
		logic zp_zero;
		logic zmore;
		logic bmore;
	} stat_t;

	function automatic uword_t ucode(input step_t pc);
		uword_t w;
		case (pc)
			STEP_IDLE:  w = '{OP_LOAD,  W_NOIN,    C_NEVER,  STEP_IDLE};
			STEP_CHAR:  w = '{OP_CHAR,  W_NONE,    C_NODIG,  STEP_FIN};
			STEP_MUL:   w = '{OP_MUL,   W_NONE,    C_MORE,   STEP_MUL};
			STEP_GROW:  w = '{OP_GROW,  W_NONE,    C_NEVER,  STEP_IDLE};
			STEP_FIN:   w = '{OP_NONE,  W_NONE,    C_NOFIN,  STEP_IDLE};
			STEP_BAD:   w = '{OP_NONE,  W_NONE,    C_BAD,    STEP_ERR};
			STEP_ZCHK:  w = '{OP_NONE,  W_NONE,    C_ZPZERO, STEP_BSET};
			STEP_EMITZ: w = '{OP_EMITZ, W_OUTBUSY, C_ZMORE,  STEP_EMITZ};
			STEP_BSET:  w = '{OP_BSET,  W_NONE,    C_NEVER,  STEP_IDLE};
			STEP_EMITB: w = '{OP_EMITB, W_OUTBUSY, C_BMORE,  STEP_EMITB};
			STEP_CLEAR: w = '{OP_CLEAR, W_NONE,    C_ALWAYS, STEP_IDLE};
			STEP_ERR:   w = '{OP_ERR,   W_OUTBUSY, C_ALWAYS, STEP_CLEAR};
			default:    w = '{OP_NONE,  W_NONE,    C_ALWAYS, STEP_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic [7:0] digit_of(input logic [7:0] c);
		logic [7:0] d;
		if (c >= 8'h31 && c <= 8'h39) begin
			d = c - 8'h31;
		end else if (c >= 8'h41 && c <= 8'h48) begin
			d = c - 8'h41 + 8'd9;
		end else if (c >= 8'h4A && c <= 8'h4E) begin
			d = c - 8'h4A + 8'd17;
		end else if (c >= 8'h50 && c <= 8'h5A) begin
			d = c - 8'h50 + 8'd22;
		end else if (c >= 8'h61 && c <= 8'h6B) begin
			d = c - 8'h61 + 8'd33;
		end else if (c >= 8'h6D && c <= 8'h7A) begin
			d = c - 8'h6D + 8'd44;
		end else begin
			d = DIGIT_NONE;
		end
		return d;
	endfunction

endpackage

[sv/b58_in_if.sv]
// ----------------------------------------------------------------------------
// Base58 character channel
// Valid/ready channel carrying one text character per transaction.
// ----------------------------------------------------------------------------
interface b58_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       has_char;
	logic       end_of_text;

	modport source(output valid, text_char, has_char, end_of_text, input ready);
	modport sink(input valid, text_char, has_char, end_of_text, output ready);
endinterface

[sv/b58_out_if.sv]
// ----------------------------------------------------------------------------
// Base58 byte channel
// Valid/ready channel carrying one decoded byte or one error per transaction.
// ----------------------------------------------------------------------------
interface b58_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;
	logic       decode_error;

	modport source(output valid, out_byte, last_byte, decode_error, input ready);
	modport sink(input valid, out_byte, last_byte, decode_error, output ready);
endinterface

[sv/b58_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module b58_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/b58_seq.sv]
// ----------------------------------------------------------------------------
// Base58 decoder sequencer
// Step counter over the microprogram table, with stall and jump selection.
// ----------------------------------------------------------------------------
module b58_seq import b58_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  stat_t  st,
	output uword_t uw,
	output logic   go
);

	step_t pc_q;
	logic  stall;
	logic  take;

	assign uw = ucode(pc_q);

	always_comb begin
		case (uw.wsel)
			W_NOIN:    stall = !st.in_valid;
			W_OUTBUSY: stall = st.out_busy;
			default:   stall = 1'b0;
		endcase
	end

	always_comb begin
		case (uw.csel)
			C_ALWAYS: take = 1'b1;
			C_NODIG:  take = st.nodig;
			C_MORE:   take = st.more;
			C_NOFIN:  take = st.nofin;
			C_BAD:    take = st.bad;
			C_ZPZERO: take = st.zp_zero;
			C_ZMORE:  take = st.zmore;
			C_BMORE:  take = st.bmore;
			default:  take = 1'b0;
		endcase
	end

	assign go = !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else if (!stall) begin
			pc_q <= take ? uw.target : pc_q + step_t'(1);
		end
	end

endmodule

[sv/b58_dp.sv]
// ----------------------------------------------------------------------------
// Base58 decoder datapath
// Character decode, multiply-by-58 carry over the byte store, prefix and
// length counters, and the output register.
// ----------------------------------------------------------------------------
module b58_dp import b58_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  op_t   op,
	input  logic  go,
	output stat_t st,
	b58_in_if.sink    chars,
	b58_out_if.source bytes
);

	logic [7:0]         char_q;
	logic               has_q;
	logic               fin_q;
	len_t               zp_q;
	len_t               sl_q;
	logic               in_prefix_q;
	logic               bad_q;
	logic               fresh_q;
	logic [CARRY_W-1:0] carry_q;
	addr_t              j_q;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;
	logic               out_err_q;

	logic              ram_we;
	addr_t             ram_waddr;
	logic [7:0]        ram_wdata;
	addr_t             ram_raddr;
	logic [7:0]        rd_raw;
	logic [7:0]        rd;
	logic [7:0]        dig;
	logic              is_one;
	logic              char_bad;
	logic [LEN_W:0]    total_next;
	logic              overflow;
	logic [PROD_W-1:0] sum;
	logic              out_busy;
	logic              out_load;

	b58_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_raw)
	);

	// Entry zero reads as zero until the first write of each string.
	assign rd = (j_q == '0 && fresh_q) ? 8'h00 : rd_raw;

	assign dig        = digit_of(char_q);
	assign is_one     = in_prefix_q && (char_q == CHAR_ONE);
	assign char_bad   = ((char_q & HIGH_BIT) != 8'h00) || (dig == DIGIT_NONE);
	assign total_next = {1'b0, zp_q} + {1'b0, sl_q} + (LEN_W+1)'(1);
	assign overflow   = total_next > MAX_TOTAL;
	assign sum        = PROD_W'(rd) * PROD_W'(RADIX) + PROD_W'(carry_q);
	assign out_busy   = out_valid_q && !bytes.ready;
	assign out_load   = go && (op == OP_EMITZ || op == OP_EMITB || op == OP_ERR);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = j_q;
		ram_wdata = sum[7:0];
		ram_raddr = '0;
		case (op)
			OP_MUL: begin
				ram_we    = 1'b1;
				ram_raddr = j_q + addr_t'(1);
			end
			OP_GROW: begin
				ram_we    = (carry_q != '0) && !overflow;
				ram_waddr = sl_q[ADDR_W-1:0];
				ram_wdata = 8'(carry_q);
			end
			OP_BSET: begin
				ram_raddr = addr_t'(sl_q - len_t'(1));
			end
			OP_EMITB: begin
				ram_raddr = go ? j_q - addr_t'(1) : j_q;
			end
			default: begin
				ram_raddr = '0;
			end
		endcase
	end

	assign st.in_valid = chars.valid;
	assign st.out_busy = out_busy;
	assign st.nodig    = !has_q || bad_q || is_one || char_bad;
	assign st.more     = (len_t'(j_q) + len_t'(1)) < sl_q;
	assign st.nofin    = !fin_q;
	assign st.bad      = bad_q;
	assign st.zp_zero  = (zp_q == '0);
	assign st.zmore    = (zp_q != len_t'(1));
	assign st.bmore    = (j_q != '0);

	assign chars.ready        = (op == OP_LOAD);
	assign bytes.valid        = out_valid_q;
	assign bytes.out_byte     = out_byte_q;
	assign bytes.last_byte    = out_last_q;
	assign bytes.decode_error = out_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zp_q        <= '0;
			sl_q        <= len_t'(1);
			in_prefix_q <= 1'b1;
			bad_q       <= 1'b0;
			fresh_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !bytes.ready);
			if (go) begin
				case (op)
					OP_CHAR: begin
						if (has_q && !bad_q) begin
							if (is_one) begin
								if (overflow) begin
									bad_q <= 1'b1;
								end else begin
									zp_q <= zp_q + len_t'(1);
								end
							end else begin
								in_prefix_q <= 1'b0;
								if (char_bad) begin
									bad_q <= 1'b1;
								end
							end
						end
					end
					OP_MUL: begin
						if (j_q == '0) begin
							fresh_q <= 1'b0;
						end
					end
					OP_GROW: begin
						if (carry_q != '0) begin
							if (overflow) begin
								bad_q <= 1'b1;
							end else begin
								sl_q <= sl_q + len_t'(1);
							end
						end
					end
					OP_EMITZ: begin
						zp_q <= zp_q - len_t'(1);
					end
					OP_CLEAR: begin
						zp_q        <= '0;
						sl_q        <= len_t'(1);
						in_prefix_q <= 1'b1;
						bad_q       <= 1'b0;
						fresh_q     <= 1'b1;
					end
					default: begin
						fresh_q <= fresh_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			case (op)
				OP_LOAD: begin
					char_q <= chars.text_char;
					has_q  <= chars.has_char;
					fin_q  <= chars.end_of_text;
				end
				OP_CHAR: begin
					carry_q <= dig[CARRY_W-1:0];
					j_q     <= '0;
				end
				OP_MUL: begin
					carry_q <= sum[PROD_W-1:8];
					j_q     <= j_q + addr_t'(1);
				end
				OP_BSET: begin
					j_q <= addr_t'(sl_q - len_t'(1));
				end
				OP_EMITZ: begin
					out_byte_q <= 8'h00;
					out_last_q <= 1'b0;
					out_err_q  <= 1'b0;
				end
				OP_EMITB: begin
					out_byte_q <= rd;
					out_last_q <= (j_q == '0);
					out_err_q  <= 1'b0;
					j_q        <= j_q - addr_t'(1);
				end
				OP_ERR: begin
					out_byte_q <= 8'h00;
					out_last_q <= 1'b1;
					out_err_q  <= 1'b1;
				end
				default: begin
					j_q <= j_q;
				end
			endcase
		end
	end

endmodule

[sv/base58_decoder.sv]
// ----------------------------------------------------------------------------
// Base58 decoder
// Decodes Bitcoin-alphabet Base58 text, one character per transaction, into
// bytes, most significant first.
// ----------------------------------------------------------------------------
// The decoder takes one character transaction at a time. A leading '1', a
// transaction without a character and a character that is bad or ignored
// each pass through the load, character and finish steps; any other
// character adds a multiply step for each of the N bytes decoded so far
// (1 to 64) and a grow step, because the multiply-by-58 carry walks the
// byte store one entry per cycle through its read and write ports. On the
// transaction that ends the string the decoder sends one byte per cycle
// while the receiver is ready (zero prefix, then the stored bytes) and
// takes no new character until the last byte of the string is in the
// output register; a bad string gives a single error transaction instead.
`include "base58_decoder_assert.svh"

module base58_decoder import b58_pkg::*; (
	input logic clk,
	input logic arst_n,
	b58_in_if.sink    chars,
	b58_out_if.source bytes
);

	stat_t  st;
	uword_t uw;
	logic   go;

	b58_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.uw     (uw),
		.go     (go)
	);

	b58_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (uw.op),
		.go     (go),
		.st     (st),
		.chars  (chars),
		.bytes  (bytes)
	);

	`B58_ASSERT_NEXT(a_one_char_at_a_time, chars.valid && chars.ready, !chars.ready, "character accepted back to back")
	`B58_ASSERT_SAME(a_error_is_last, bytes.valid && bytes.decode_error, bytes.last_byte && bytes.out_byte == 8'h00, "error transaction malformed")
	`B58_ASSERT_NEXT(a_stall_holds_step, uw.wsel == W_OUTBUSY && st.out_busy, $stable(uw), "sequencer moved while output stalled")

endmodule

[verif/b58_scoreboard_pkg.sv]
// ----------------------------------------------------------------------------
// Base58 decoder scoreboard
// Keeps a bit-exact copy of the decoder state, works out the bytes that each
// accepted character transaction should produce and checks the decoded
// bytes against them in order.
// ----------------------------------------------------------------------------
package b58_scoreboard_pkg;

	import b58_pkg::*;

	localparam string B58_ALPHABET =
		"123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

	typedef struct {
		logic [7:0] value;
		logic       last;
		logic       err;
	} decoded_byte_t;

	class b58_decode_scoreboard;

		decoded_byte_t expected_bytes[$];
		logic [7:0]    big_number[STORE_DEPTH];
		int            number_len;
		int            zero_count;
		bit            reading_ones;
		bit            string_bad;
		int            mismatches;
		int            bytes_checked;
		int            error_results;
		int            strings_ended;
		int            widest_output;

		function new();
			mismatches    = 0;
			bytes_checked = 0;
			error_results = 0;
			strings_ended = 0;
			widest_output = 0;
			restart_string();
		endfunction

		function void restart_string();
			foreach (big_number[j]) big_number[j] = 8'h00;
			number_len   = 1;
			zero_count   = 0;
			reading_ones = 1'b1;
			string_bad   = 1'b0;
		endfunction

		function void queue_expected(decoded_byte_t b);
			expected_bytes.insert(expected_bytes.size(), b);
		endfunction

		function int digit_value(logic [7:0] c);
			int d;
			d = -1;
			if ((c & HIGH_BIT) == 8'h00) begin
				for (int k = 0; k < RADIX; k++) begin
					if (B58_ALPHABET[k] == c) d = k;
				end
			end
			return d;
		endfunction

		function void fold_char(logic [7:0] c);
			int d;
			int carry;
			if (string_bad) return;
			if (reading_ones && c == CHAR_ONE) begin
				if (zero_count + number_len + 1 > MAX_OUT) string_bad = 1'b1;
				else zero_count++;
				return;
			end
			reading_ones = 1'b0;
			d = digit_value(c);
			if (d < 0) begin
				string_bad = 1'b1;
				return;
			end
			carry = d;
			for (int j = 0; j < number_len; j++) begin
				carry = carry + int'(big_number[j]) * RADIX;
				big_number[j] = carry[7:0];
				carry = carry >> 8;
			end
			if (carry > 0) begin
				if (zero_count + number_len + 1 > MAX_OUT || number_len >= STORE_DEPTH) begin
					string_bad = 1'b1;
					return;
				end
				big_number[number_len] = carry[7:0];
				number_len++;
			end
		endfunction

		// Called for every accepted character transaction.
		function void note_char(logic [7:0] c, logic has, logic fin);
			int total;
			if (has) fold_char(c);
			if (!fin) return;
			strings_ended++;
			if (string_bad) begin
				queue_expected(decoded_byte_t'{8'h00, 1'b1, 1'b1});
			end else begin
				total = zero_count + number_len;
				if (total > widest_output) widest_output = total;
				for (int i = 0; i < zero_count; i++) begin
					queue_expected(decoded_byte_t'{8'h00, i == total - 1, 1'b0});
				end
				for (int i = 0; i < number_len; i++) begin
					queue_expected(decoded_byte_t'{big_number[number_len - 1 - i],
						zero_count + i == total - 1, 1'b0});
				end
			end
			restart_string();
		endfunction

		// Called for every accepted byte transaction.
		function void check_byte(logic [7:0] value, logic last, logic err);
			decoded_byte_t want;
			bytes_checked++;
			if (err === 1'b1) error_results++;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%t: unexpected byte 0x%h last=%b err=%b", $realtime, value,
						last, err);
				end
				return;
			end
			want = expected_bytes.pop_front();
			if (want.value !== value || want.last !== last || want.err !== err) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%t: byte mismatch: expected 0x%h last=%b err=%b, got 0x%h last=%b err=%b",
						$realtime, want.value, want.last, want.err, value, last, err);
				end
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

	endclass

endpackage

[verif/tb_base58_decoder.sv]
// ----------------------------------------------------------------------------
// Base58 decoder testbench
// Sends directed and random Base58 strings, one character per transaction,
// with random gaps on both channels, and checks every decoded byte and error
// transaction against a scoreboard that tracks the decoder state.
// ----------------------------------------------------------------------------
module tb_base58_decoder;

	timeunit 1ns;
	timeprecision 1ps;

	import b58_pkg::*;
	import b58_scoreboard_pkg::*;

	localparam int ITEM_TARGET   = 420;
	localparam int PHASE_ITEMS   = 140;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 200;
	localparam logic [7:0] CHAR_Z = 8'h7A;

	logic clk;
	logic arst_n;
	int   cycles = 0;
	int   items_sent = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   big_strings = 0;
	logic [7:0] text_buf[$];
	b58_decode_scoreboard sb;

	b58_in_if  chars_if();
	b58_out_if bytes_if();

	base58_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars_if),
		.bytes(bytes_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d bytes outstanding.", cycles,
				sb.pending());
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (chars_if.valid && chars_if.ready) begin
				sb.note_char(chars_if.text_char, chars_if.has_char, chars_if.end_of_text);
			end
			if (bytes_if.valid && bytes_if.ready) begin
				sb.check_byte(bytes_if.out_byte, bytes_if.last_byte, bytes_if.decode_error);
			end
		end
	end

	initial begin
		bytes_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			bytes_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_char(input logic [7:0] c, input logic has, input logic fin);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(negedge clk);
		end
		chars_if.valid       <= 1'b1;
		chars_if.text_char   <= c;
		chars_if.has_char    <= has;
		chars_if.end_of_text <= fin;
		do @(posedge clk); while (!chars_if.ready);
		if (has || fin) items_sent++;
	endtask

	function automatic void append_char(input logic [7:0] c);
		text_buf.insert(text_buf.size(), c);
	endfunction

	task automatic send_text_buf(input bit split_end, input int noop_pct);
		for (int i = 0; i < text_buf.size(); i++) begin
			if ($urandom_range(99) < noop_pct) send_char(8'($urandom), 1'b0, 1'b0);
			send_char(text_buf[i], 1'b1, !split_end && i == text_buf.size() - 1);
		end
		if (split_end || text_buf.size() == 0) send_char(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic send_text(input string s, input bit split_end);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++) append_char(s[i]);
		send_text_buf(split_end, 0);
	endtask

	task automatic wait_for_bytes();
		@(negedge clk);
		chars_if.valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
	endtask

	function automatic logic [7:0] random_digit_char();
		return B58_ALPHABET[$urandom_range(0, RADIX - 1)];
	endfunction

	function automatic logic [7:0] random_bad_char();
		string outsiders;
		outsiders = "0IOl+/ ";
		case ($urandom_range(2))
			0: return 8'($urandom_range(128, 255));
			1: return outsiders[$urandom_range(0, outsiders.len() - 1)];
			default: return 8'($urandom_range(0, 127));
		endcase
	endfunction

	task automatic make_ordinary_text();
		int prefix;
		int body;
		text_buf.delete();
		prefix = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 4);
		body = $urandom_range(0, 10);
		repeat (prefix) append_char(CHAR_ONE);
		repeat (body) append_char(random_digit_char());
		if ($urandom_range(99) < 12) begin
			text_buf.insert($urandom_range(0, text_buf.size()), random_bad_char());
		end
	endtask

	task automatic make_big_text();
		text_buf.delete();
		case (big_strings % 4)
			0: repeat (88) append_char(CHAR_Z);
			1: repeat (63) append_char(CHAR_ONE);
			2: repeat (64) append_char(CHAR_ONE);
			default: repeat (87) append_char(CHAR_Z);
		endcase
		big_strings++;
	endtask

	task automatic set_phase(input int phase);
		case (phase)
			0: begin
				send_idle_pct = 32;
				recv_idle_pct = 77;
			end
			1: begin
				send_idle_pct = 77;
				recv_idle_pct = 32;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	initial begin
		int phase;
		int string_count;
		sb = new();
		arst_n               = 1'b0;
		chars_if.valid       = 1'b0;
		chars_if.text_char   = 8'h00;
		chars_if.has_char    = 1'b0;
		chars_if.end_of_text = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		phase = 0;
		set_phase(phase);

		send_text("", 1'b0);
		send_text("1", 1'b0);
		send_text("1z", 1'b0);
		send_text("zz", 1'b0);
		send_char(8'hA5, 1'b0, 1'b0);
		send_text("2", 1'b1);
		send_char(8'hFF, 1'b1, 1'b1);
		send_char(8'h80, 1'b1, 1'b1);
		send_text("0", 1'b0);
		send_text("I", 1'b0);
		send_text("Olz", 1'b0);
		send_text("21", 1'b0);
		send_text("11z", 1'b1);

		string_count = 0;
		while (items_sent < ITEM_TARGET) begin
			if (items_sent / PHASE_ITEMS > phase && phase < 2) begin
				wait_for_bytes();
				phase++;
				set_phase(phase);
			end
			if (string_count % 6 == 2) make_big_text();
			else make_ordinary_text();
			send_text_buf($urandom_range(99) < 30, 5);
			string_count++;
		end

		wait_for_bytes();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Decoded %0d strings from %0d character transactions: %0d bytes checked,",
			sb.strings_ended, items_sent, sb.bytes_checked);
		$display("%0d of them error transactions, widest output %0d bytes, %0d mismatches.",
			sb.error_results, sb.widest_output, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
